// ===== hw/rtl/sfa_pkg.sv =====
// Package for the selectable FIR/IIR audio filter: mode codes, widths, coefficient tables.
// No dependencies.
`timescale 1ns / 1ps
package sfa_pkg;

  localparam int SampleW = 10;
  localparam int HistW   = 32;
  localparam int HistFrac = 16;
  localparam logic [9:0] SampleMax = 10'd1023;

  localparam logic [1:0] ModeBypass = 2'd0;
  localparam logic [1:0] ModeFir    = 2'd1;
  localparam logic [1:0] ModeIir    = 2'd2;

  localparam int FirTabLen = 51;
  localparam int IirTabLen = 5;

  typedef int fir_tab_t [FirTabLen];
  typedef int iir_tab_t [IirTabLen];

  // coefficients in units of 1e-4
  localparam fir_tab_t FirTab = '{
    2, 5, 8, 12, 18, 25, 33, 42, 52, 63, 74, 85, 96, 106, 115, 123,
    129, 133, 135, 134, 131, 125, 116, 104, 89, 71, 9500, 71, 89, 104, 116, 125,
    131, 134, 135, 133, 129, 123, 115, 106, 96, 85, 74, 63, 52, 42, 33, 25,
    18, 12, 8};
  localparam iir_tab_t IirBTab = '{67, 269, 404, 269, 67};
  localparam iir_tab_t IirATab = '{10000, -23741, 23147, -10543, 1873};

  // round to nearest, ties away from zero
  function automatic longint to_fixed(input int n, input int frac);
    longint s;
    longint m;
    s = longint'(1) << frac;
    if (n >= 0) begin
      m = (longint'(n) * s + 64'sd5000) / 64'sd10000;
    end else begin
      m = -((longint'(-n) * s + 64'sd5000) / 64'sd10000);
    end
    return m;
  endfunction

  function automatic longint fir_coef(input int i, input int frac);
    return (i < FirTabLen) ? to_fixed(FirTab[i], frac) : 64'sd0;
  endfunction

  function automatic longint iir_b(input int i, input int frac);
    return (i < IirTabLen) ? to_fixed(IirBTab[i], frac) : 64'sd0;
  endfunction

  function automatic longint iir_a(input int i, input int frac);
    return (i < IirTabLen) ? to_fixed(IirATab[i], frac) : 64'sd0;
  endfunction

endpackage

// ===== hw/rtl/sfa_cell.sv =====
// One delay cell of the rotating history ring: holds a value, hands it on each shift.
// Depends on nothing.
`timescale 1ns / 1ps
module sfa_cell #(
  parameter int W = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clr_i,
  input  logic         shift_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (clr_i) begin
      val_q <= '0;
    end else if (shift_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;
endmodule

// ===== hw/rtl/sfa_mac.sv =====
// Shared MAC: 32x32 signed product registered, added to or subtracted from a 64-bit sum.
// Depends on nothing.
`timescale 1ns / 1ps
module sfa_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic               sub_i,
  output logic signed [63:0] acc_o
);
  logic signed [63:0] prod_q;
  logic               prod_vld_q, sub_q;
  logic signed [63:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= en_i;
      if (clr_i) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= sub_q ? acc_q - prod_q : acc_q + prod_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    sub_q  <= sub_i;
  end

  assign acc_o = acc_q;
endmodule

// ===== hw/rtl/selectable_fir_iir_audio_filter.sv =====
// Top level of the selectable FIR/IIR audio filter: sequencer, history rings, one MAC.
// Depends on sfa_pkg, sfa_cell, sfa_mac.
//
// channel | signals                           | direction
// in      | in_valid_i, in_stall_o, sample_in_i   | request in
// out     | out_valid_o, out_stall_i, sample_out_o| request out
// cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i  | mode write
//
// After acceptance, bypass goes straight to the output state; FIR and IIR step the
// single shared multiplier through the history rings, then pass the wait, done and out states.
// The next request is taken only after the result has been raised and taken.
// Rings rotate one cell per product so each coefficient meets its tap at the ring head.
// Reset clears mode and histories; a mode write clears histories.
// A result held by out_stall_i blocks the next request until taken.
`timescale 1ns / 1ps
module selectable_fir_iir_audio_filter #(
  parameter int FIR_LENGTH = 51,
  parameter int IIR_DEGREE = 4,
  parameter int COEF_FRACTION_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [9:0] sample_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [9:0] sample_out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);
  import sfa_pkg::*;

  localparam int CntW = $clog2(FIR_LENGTH + 2 * IIR_DEGREE + 2);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFir  = 3'd1;
  localparam logic [2:0] StIir  = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StDone = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]      st_q, st_d;
  logic [1:0]      mode_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [2:0]      wait_q;
  logic [9:0]      res_q;
  logic [9:0]      res_x_q;
  logic            out_vld_q;
  logic            clr;

  assign clr         = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = (st_q == StIdle) && !out_vld_q;
  assign in_stall_o  = (st_q != StIdle) || out_vld_q || cfg_valid_i;
  wire   acc_in      = in_valid_i && !in_stall_o;

  // FIR ring: fir_q[0] is the head; rotation shifts toward lower index
  logic [9:0] fir_q [FIR_LENGTH];
  logic [9:0] fir_d [FIR_LENGTH];
  logic       fir_sh;
  logic       fir_ins;

  // IIR rings: x past and y past
  logic [9:0]       xin_q [IIR_DEGREE];
  logic [9:0]       xin_d [IIR_DEGREE];
  logic [HistW-1:0] yh_q [IIR_DEGREE];
  logic [HistW-1:0] yh_d [IIR_DEGREE];
  logic             iir_x_sh;
  logic             iir_y_sh;
  logic             iir_ins;
  logic [HistW-1:0] y_new;

  // insert: new sample enters at head, others move up one (oldest dropped)
  // rotate: head goes to tail, others move down one
  always_comb begin
    for (int i = 0; i < FIR_LENGTH; i++) begin
      if (fir_ins) begin
        fir_d[i] = (i == 0) ? sample_in_i : fir_q[(i + FIR_LENGTH - 1) % FIR_LENGTH];
      end else begin
        fir_d[i] = fir_q[(i + 1) % FIR_LENGTH];
      end
    end
    for (int i = 0; i < IIR_DEGREE; i++) begin
      if (iir_ins) begin
        xin_d[i] = (i == 0) ? res_x_q : xin_q[(i + IIR_DEGREE - 1) % IIR_DEGREE];
        yh_d[i]  = (i == 0) ? y_new : yh_q[(i + IIR_DEGREE - 1) % IIR_DEGREE];
      end else begin
        xin_d[i] = xin_q[(i + 1) % IIR_DEGREE];
        yh_d[i]  = yh_q[(i + 1) % IIR_DEGREE];
      end
    end
  end

  for (genvar g = 0; g < FIR_LENGTH; g++) begin : g_fir
    sfa_cell #(.W(10)) u_cell (
      .clk_i, .rst_ni, .clr_i(clr), .shift_i(fir_sh), .d_i(fir_d[g]), .q_o(fir_q[g]));
  end
  for (genvar g = 0; g < IIR_DEGREE; g++) begin : g_iir
    sfa_cell #(.W(10)) u_x (
      .clk_i, .rst_ni, .clr_i(clr), .shift_i(iir_x_sh), .d_i(xin_d[g]), .q_o(xin_q[g]));
    sfa_cell #(.W(HistW)) u_y (
      .clk_i, .rst_ni, .clr_i(clr), .shift_i(iir_y_sh), .d_i(yh_d[g]), .q_o(yh_q[g]));
  end

  // coefficient lookup
  logic signed [31:0] coef;
  logic signed [31:0] opnd;
  logic               mac_en, mac_sub, mac_clr;
  logic signed [63:0] acc;
  logic [CntW-1:0]    half;

  assign half = cnt_q >> 1;

  always_comb begin
    coef    = '0;
    opnd    = '0;
    mac_sub = 1'b0;
    for (int i = 0; i < FIR_LENGTH; i++) begin
      if (st_q == StFir && cnt_q == CntW'(i)) begin
        coef = 32'(fir_coef(i, COEF_FRACTION_BITS));
      end
    end
    if (st_q == StFir) begin
      opnd = {22'd0, fir_q[0]};
    end
    if (st_q == StIir) begin
      if (cnt_q == '0) begin
        coef = 32'(iir_b(0, COEF_FRACTION_BITS));
        opnd = {6'd0, res_x_q, 16'd0};
      end else if (cnt_q[0]) begin
        for (int i = 1; i <= IIR_DEGREE; i++) begin
          if (half == CntW'(i - 1)) coef = 32'(iir_b(i, COEF_FRACTION_BITS));
        end
        opnd = {6'd0, xin_q[0], 16'd0};
      end else begin
        for (int i = 1; i <= IIR_DEGREE; i++) begin
          if (half == CntW'(i)) coef = 32'(iir_a(i, COEF_FRACTION_BITS));
        end
        opnd    = yh_q[0];
        mac_sub = 1'b1;
      end
    end
  end

  assign mac_en  = (st_q == StFir) || (st_q == StIir);
  assign mac_clr = acc_in;

  sfa_mac u_mac (
    .clk_i, .rst_ni, .clr_i(mac_clr), .en_i(mac_en), .a_i(coef), .b_i(opnd),
    .sub_i(mac_sub), .acc_o(acc));

  // IIR: odd steps use x ring, even steps (>0) use y ring; each ring rotates after use
  assign fir_ins  = acc_in && (mode_q == ModeFir);
  assign fir_sh   = fir_ins || (st_q == StFir);
  assign iir_ins  = (st_q == StDone) && (mode_q == ModeIir);
  assign iir_x_sh = iir_ins || ((st_q == StIir) && cnt_q[0]);
  assign iir_y_sh = iir_ins || ((st_q == StIir) && (cnt_q != '0) && !cnt_q[0]);

  // y = acc / 2^F toward zero, saturated to 32 bits in IIR mode
  logic signed [63:0] qt;
  logic signed [63:0] ys;
  logic signed [63:0] yi;
  logic [9:0]         clamped;

  always_comb begin
    logic signed [63:0] rnd;
    rnd = acc + ((acc < 0) ? ((64'sd1 <<< COEF_FRACTION_BITS) - 64'sd1) : 64'sd0);
    qt  = rnd >>> COEF_FRACTION_BITS;
    ys  = qt;
    if (mode_q == ModeIir) begin
      if (qt > 64'sd2147483647) ys = 64'sd2147483647;
      if (qt < -64'sd2147483648) ys = -64'sd2147483648;
    end
    y_new = ys[HistW-1:0];
    if (mode_q == ModeIir) begin
      yi = (ys + ((ys < 0) ? 64'sd65535 : 64'sd0)) >>> HistFrac;
    end else begin
      yi = ys;
    end
    if (yi < 0) clamped = '0;
    else if (yi > 64'sd1023) clamped = SampleMax;
    else clamped = yi[9:0];
  end

  // the x ring is rotated once per x product, a full turn per pass, so the opnd order matches past inputs
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      StIdle: begin
        cnt_d = '0;
        if (acc_in) begin
          if (mode_q == ModeFir) st_d = StFir;
          else if (mode_q == ModeIir) st_d = StIir;
          else st_d = StOut;
        end
      end
      StFir: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(FIR_LENGTH - 1)) st_d = StWait;
      end
      StIir: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(2 * IIR_DEGREE)) st_d = StWait;
      end
      StWait: begin
        if (wait_q == 3'd1) st_d = StDone;
      end
      StDone: st_d = StOut;
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      cnt_q     <= '0;
      mode_q    <= ModeBypass;
      out_vld_q <= 1'b0;
      wait_q    <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (clr) mode_q <= cfg_data_i;
      wait_q <= (st_q == StWait) ? wait_q + 3'd1 : 3'd0;
      if (st_q == StOut) out_vld_q <= 1'b1;
      else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) res_x_q <= sample_in_i;
    if (st_q == StDone) res_q <= clamped;
    else if (st_q == StIdle && acc_in && mode_q != ModeFir && mode_q != ModeIir) begin
      res_q <= sample_in_i;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = res_q;

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> st_q == StIdle) else $error("result held while busy");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> st_q == StIdle && !out_vld_q) else $error("mode write while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |=> out_vld_q) else $error("result not raised");
endmodule
